FILE: rtl/tmcw_pkg.sv
package tmcw_pkg;

  localparam int unsigned POS_BITS  = 11;
  localparam int unsigned CELL_BITS = 16;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;

  typedef enum logic [2:0] {
    CMD_PUT,
    CMD_NEWLINE,
    CMD_CLEAR,
    CMD_READ,
    CMD_NOP
  } tmcw_kind_t;

  // cell layout: char [7:0], foreground [11:8], background [15:12]
  typedef struct packed {
    tmcw_kind_t           kind;
    logic                 rd_ok;
    logic [CELL_BITS-1:0] cell_word;
  } tmcw_cmd_t;

  function automatic logic [CELL_BITS-1:0] blank_keep_fore(input logic [CELL_BITS-1:0] data);
    return {4'h0, data[11:8], SPACE_CODE};
  endfunction

endpackage

FILE: rtl/tmcw_if.sv
interface tmcw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] char_code;
  logic [3:0] fore_colour;
  logic [3:0] back_colour;
  logic [4:0] read_row;
  logic [6:0] read_column;

  modport source (
    output valid, operation, char_code, fore_colour, back_colour, read_row, read_column,
    input  ready
  );
  modport sink (
    input  valid, operation, char_code, fore_colour, back_colour, read_row, read_column,
    output ready
  );
endinterface

interface tmcw_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] cursor_position;
  logic [7:0]  cell_char;
  logic [3:0]  cell_fore;
  logic [3:0]  cell_back;

  modport source (
    output valid, cursor_position, cell_char, cell_fore, cell_back,
    input  ready
  );
  modport sink (
    input  valid, cursor_position, cell_char, cell_fore, cell_back,
    output ready
  );
endinterface

FILE: rtl/tmcw_ram.sv
module tmcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/tmcw_front.sv
module tmcw_front
  import tmcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  localparam int ADDR_W = $clog2(ROWS * COLUMNS)
) (
  tmcw_in_if.sink           in_ch,
  input  logic              enable,
  input  logic              q_full,
  output logic              q_push,
  output tmcw_cmd_t         q_cmd,
  output logic [ADDR_W-1:0] q_addr
);

  assign in_ch.ready = enable && !q_full;
  assign q_push      = in_ch.valid && in_ch.ready;

  always_comb begin
    q_cmd.cell_word = {in_ch.back_colour, in_ch.fore_colour, in_ch.char_code};
    q_cmd.rd_ok     = (32'(in_ch.read_row) < ROWS) && (32'(in_ch.read_column) < COLUMNS);
    case (in_ch.operation)
      OP_PUT:   q_cmd.kind = (in_ch.char_code == NEWLINE_CODE) ? CMD_NEWLINE : CMD_PUT;
      OP_CLEAR: q_cmd.kind = CMD_CLEAR;
      OP_READ:  q_cmd.kind = CMD_READ;
      default:  q_cmd.kind = CMD_NOP;
    endcase
  end

  // only meaningful when the read is in range
  assign q_addr = ADDR_W'(in_ch.read_row * COLUMNS + in_ch.read_column);

endmodule

FILE: rtl/tmcw_queue.sv
module tmcw_queue #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] rdata
);

  logic [W-1:0] entry_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   count_r;

  assign full  = (count_r == 2'd2);
  assign valid = (count_r != 2'd0);
  assign rdata = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/tmcw_back.sv
module tmcw_back
  import tmcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  localparam int ADDR_W = $clog2(ROWS * COLUMNS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  tmcw_cmd_t         q_cmd,
  input  logic [ADDR_W-1:0] q_addr,
  output logic              q_pop,
  output logic              ready_for_items,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [15:0]       ram_wdata,
  output logic              ram_re,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [15:0]       ram_rdata,
  tmcw_out_if.source        out_ch
);

  localparam int COL_W = $clog2(COLUMNS);
  localparam int POS_W = (ADDR_W > POS_BITS) ? ADDR_W : POS_BITS;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ROWS * COLUMNS - 1);
  localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SWEEP,
    ST_DONE
  } state_t;

  state_t              state_r;
  logic [ADDR_W-1:0]   base_r;
  logic [COL_W-1:0]    col_r;
  logic [ADDR_W-1:0]   sw_addr_r;
  logic                sw_active_r;
  logic                sw_copy_r;
  logic                pend_r;
  logic [ADDR_W-1:0]   pend_addr_r;
  logic                pend_copy_r;
  logic                rd_flag_r;
  logic                out_valid_r;
  logic [POS_BITS-1:0] out_pos_r;
  logic [15:0]         out_cell_r;

  logic [ADDR_W-1:0]   cur_idx;
  logic [POS_W-1:0]    pos_ext;
  logic                start;

  assign cur_idx = base_r + ADDR_W'(col_r);
  assign pos_ext = POS_W'(cur_idx);
  assign start   = (state_r == ST_IDLE) && q_valid && !out_valid_r;

  assign ready_for_items = (state_r != ST_INIT);

  assign out_ch.valid           = out_valid_r;
  assign out_ch.cursor_position = out_pos_r;
  assign out_ch.cell_char       = out_cell_r[7:0];
  assign out_ch.cell_fore       = out_cell_r[11:8];
  assign out_ch.cell_back       = out_cell_r[15:12];

  always_comb begin
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cur_idx;
    ram_wdata = q_cmd.cell_word;
    ram_re    = 1'b0;
    ram_raddr = q_addr;
    case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = sw_addr_r;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        if (start) begin
          q_pop  = 1'b1;
          ram_we = (q_cmd.kind == CMD_PUT);
          ram_re = (q_cmd.kind == CMD_READ) && q_cmd.rd_ok;
        end
      end
      ST_SWEEP: begin
        // each cell's write comes in the cycle after its read
        ram_we    = pend_r;
        ram_waddr = pend_copy_r ? (pend_addr_r - ROW_STEP) : pend_addr_r;
        ram_wdata = pend_copy_r ? ram_rdata : blank_keep_fore(ram_rdata);
        ram_re    = sw_active_r;
        ram_raddr = sw_addr_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      base_r      <= '0;
      col_r       <= '0;
      sw_addr_r   <= '0;
      sw_active_r <= 1'b0;
      sw_copy_r   <= 1'b0;
      pend_r      <= 1'b0;
      rd_flag_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_INIT: begin
          if (sw_addr_r == LAST_ADDR) begin
            sw_addr_r <= '0;
            state_r   <= ST_IDLE;
          end else begin
            sw_addr_r <= sw_addr_r + ADDR_W'(1);
          end
        end
        ST_IDLE: begin
          if (start) begin
            state_r   <= ST_DONE;
            rd_flag_r <= 1'b0;
            case (q_cmd.kind)
              CMD_PUT, CMD_NEWLINE: begin
                if (q_cmd.kind == CMD_NEWLINE || col_r == LAST_COL) begin
                  col_r <= '0;
                  if (base_r == LAST_BASE) begin
                    // scroll: copy rows up, then blank the bottom row
                    sw_addr_r   <= ROW_STEP;
                    sw_copy_r   <= 1'b1;
                    sw_active_r <= 1'b1;
                    state_r     <= ST_SWEEP;
                  end else begin
                    base_r <= base_r + ROW_STEP;
                  end
                end else begin
                  col_r <= col_r + COL_W'(1);
                end
              end
              CMD_CLEAR: begin
                col_r       <= '0;
                base_r      <= '0;
                sw_addr_r   <= '0;
                sw_copy_r   <= 1'b0;
                sw_active_r <= 1'b1;
                state_r     <= ST_SWEEP;
              end
              CMD_READ: begin
                rd_flag_r <= q_cmd.rd_ok;
              end
              default: ;
            endcase
          end
        end
        ST_SWEEP: begin
          pend_r      <= sw_active_r;
          pend_addr_r <= sw_addr_r;
          pend_copy_r <= sw_copy_r;
          if (sw_active_r) begin
            if (sw_addr_r == LAST_ADDR) begin
              if (sw_copy_r) begin
                sw_addr_r <= LAST_BASE;
                sw_copy_r <= 1'b0;
              end else begin
                sw_active_r <= 1'b0;
              end
            end else begin
              sw_addr_r <= sw_addr_r + ADDR_W'(1);
            end
          end
          if (!sw_active_r && !pend_r) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          out_valid_r <= 1'b1;
          out_pos_r   <= pos_ext[POS_BITS-1:0];
          out_cell_r  <= rd_flag_r ? ram_rdata : '0;
          state_r     <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/text_mode_console_writer_top.sv
// character-cell text console, ROWS x COLUMNS cells of 16 bits
// in_ch: one operation per transfer (put character, clear screen, read cell)
// out_ch: exactly one result per operation, in order, carrying the linear
//   cursor position and, for an in-range read, the cell contents
// a two-entry command queue sits between the input decode and the executor,
// so new operations are taken while a result waits in the output register
// put, newline, read and no-op: the operation is registered in the queue, popped
//   by the idle executor, then goes through the done state into the output register
// a put or newline that runs past the bottom row scrolls the screen, and a
//   clear blanks it: both walk the cell memory one cell per cycle through its
//   single write port before that result is produced
// reset: cursor goes home and the executor writes zero to every cell, one cell
//   per cycle; in_ch.ready stays low during that pass
// when out_ch stalls, the pending result holds, the executor waits and the
//   queue fills; in_ch.ready drops once the queue is full
module text_mode_console_writer_top
  import tmcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  tmcw_in_if.sink     in_ch,
  tmcw_out_if.source  out_ch
);

  localparam int ADDR_W = $clog2(ROWS * COLUMNS);
  localparam int QW     = $bits(tmcw_cmd_t) + ADDR_W;

  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  tmcw_cmd_t         f_cmd;
  logic [ADDR_W-1:0] f_addr;
  logic [QW-1:0]     q_rdata;
  tmcw_cmd_t         b_cmd;
  logic [ADDR_W-1:0] b_addr;
  logic              ready_for_items;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [15:0]       ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [15:0]       ram_rdata;

  tmcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .in_ch  (in_ch),
    .enable (ready_for_items),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (f_cmd),
    .q_addr (f_addr)
  );

  tmcw_queue #(
    .W (QW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({f_cmd, f_addr}),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  assign b_cmd  = tmcw_cmd_t'(q_rdata[QW-1:ADDR_W]);
  assign b_addr = q_rdata[ADDR_W-1:0];

  tmcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_cmd           (b_cmd),
    .q_addr          (b_addr),
    .q_pop           (q_pop),
    .ready_for_items (ready_for_items),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata),
    .out_ch          (out_ch)
  );

  tmcw_ram #(
    .WIDTH (CELL_BITS),
    .DEPTH (ROWS * COLUMNS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
